@@ rtl/core/itsf_pkg.sv @@
// Shared constants, codes and types for the IPv4/TCP signature filter.
// Used by every module under rtl/core; depends on nothing.
package itsf_pkg;

  localparam int ALLOW_ENTRIES = 128;
  localparam int INDEX_W       = 7;
  localparam int ADDR_W        = 32;
  localparam int TREE_FAN      = 8;
  localparam int TREE_L1       = (ALLOW_ENTRIES + TREE_FAN - 1) / TREE_FAN;
  localparam int TREE_L2       = (TREE_L1 + TREE_FAN - 1) / TREE_FAN;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;

  localparam logic [7:0] POS_ETYPE_HI  = 8'd12;
  localparam logic [7:0] POS_ETYPE_LO  = 8'd13;
  localparam logic [7:0] POS_IHL       = 8'd14;
  localparam logic [7:0] POS_PROTO     = 8'd23;
  localparam logic [7:0] POS_SRC_FIRST = 8'd26;
  localparam logic [7:0] POS_SRC_LAST  = 8'd29;
  localparam logic [7:0] POS_MAX       = 8'd255;
  localparam logic [7:0] POS_IP_FIRST  = 8'd15;

  localparam logic [7:0] ETH_HDR_LEN  = 8'd14;
  localparam logic [7:0] TCP_DOFF_POS = 8'd12;
  localparam logic [8:0] MIN_FRAME    = 9'd34;
  localparam logic [8:0] TCP_MIN_LEN  = 9'd20;
  localparam logic [8:0] PAYLOAD_MIN  = 9'd14;
  localparam logic [8:0] SIG_LEN      = 9'd11;
  localparam logic [3:0] HDR_MIN      = 4'd5;

  localparam logic [2:0] CAUSE_NOT_IP    = 3'd0;
  localparam logic [2:0] CAUSE_LISTED    = 3'd1;
  localparam logic [2:0] CAUSE_NOT_TCP   = 3'd2;
  localparam logic [2:0] CAUSE_CLEAN     = 3'd3;
  localparam logic [2:0] CAUSE_SIGNATURE = 3'd4;

  typedef struct packed {
    logic                 write;
    logic [INDEX_W-1:0]   index;
    logic [ADDR_W-1:0]    address;
    logic                 valid;
    logic                 lookup;
    logic [ADDR_W-1:0]    key;
  } allow_ctl_t;

  function automatic logic [7:0] sig_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "G";
      4'd1:    c = "E";
      4'd2:    c = "T";
      4'd3:    c = " ";
      4'd4:    c = "/";
      4'd5:    c = "a";
      4'd6:    c = "t";
      4'd7:    c = "t";
      4'd8:    c = "a";
      4'd9:    c = "c";
      4'd10:   c = "k";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/ipv4_tcp_signature_filter_unit.sv @@
// Top level of the IPv4/TCP signature filter: frame parser, verdict logic,
// allowlist cell row and match tree. Depends on itsf_pkg, itsf_cell,
// itsf_match_tree.
//
// Usage:
//   Input channel (in_*): one beat per frame byte (in_tuser = 0) with in_tlast
//   on the final byte, or one allowlist write (in_tuser = 1) that loads slot
//   entry_index with entry_address and entry_valid. Writes may sit between
//   bytes of a frame without disturbing it.
//   Output channel (out_*): one verdict beat per frame, drop in bit 0 and
//   cause in bits 3:1, valid the cycle after the last byte is taken.
//   Throughput: one beat per cycle while in_tready is high.
//   The source address is compared in all 128 cells at once when frame byte 29
//   arrives; the cell match registers and the three-level match tree settle
//   before the earliest byte (33) on which the allowlist can decide a verdict.
//   Reset: all slots invalid, frame state cleared, no verdict pending.
//   Stall: the verdict register holds while out_tready is low; in_tready drops
//   only while a held verdict is not being taken.
module ipv4_tcp_signature_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // data_byte[7:0], entry_index[14:8],
                                  // entry_address[46:15], entry_valid[47]
  input  logic        in_tuser,   // op
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // drop[0], cause[3:1], zero[7:4]
);
  import itsf_pkg::*;

  logic in_fire, byte_fire, wr_fire, frame_end;
  logic [7:0] data_byte;

  logic [7:0]        pos_r, pos_nxt;
  logic              eth_ok_r, eth_ok_nxt;
  logic [3:0]        hw_r, hw_nxt;
  logic              tcp_r, tcp_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [7:0]        ps_r, ps_nxt;
  logic              prefix_r, prefix_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              drop_r, drop_nxt;
  logic [2:0]        cause_r, cause_nxt;

  logic [7:0] tcp_start, sig_off;
  logic [8:0] len9, tcp_end9, ps9;
  logic       listed;

  allow_ctl_t                ctl;
  logic [ALLOW_ENTRIES-1:0]  sel;
  logic [ALLOW_ENTRIES-1:0]  match;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign byte_fire = in_fire && (in_tuser == OP_BYTE);
  assign wr_fire   = in_fire && (in_tuser == OP_WRITE);
  assign frame_end = byte_fire && in_tlast;
  assign data_byte = in_tdata[7:0];

  assign tcp_start = ETH_HDR_LEN + {2'b00, hw_r, 2'b00};
  assign sig_off   = pos_r - ps_r;
  assign len9      = (pos_r == POS_MAX) ? {1'b0, POS_MAX} : {1'b0, pos_r} + 9'd1;
  assign tcp_end9  = {1'b0, tcp_start} + TCP_MIN_LEN;
  assign ps9       = {1'b0, ps_r};

  always_comb begin
    ctl.write   = wr_fire;
    ctl.index   = in_tdata[14:8];
    ctl.address = in_tdata[46:15];
    ctl.valid   = in_tdata[47];
    ctl.lookup  = byte_fire && (pos_r == POS_SRC_LAST);
    ctl.key     = {src_r[ADDR_W-9:0], data_byte};
  end

  for (genvar i = 0; i < ALLOW_ENTRIES; i++) begin : g_cell
    assign sel[i] = (32'(ctl.index) == i);
    itsf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl),
      .sel_i   (sel[i]),
      .match_o (match[i])
    );
  end

  itsf_match_tree u_tree (
    .clk      (clk),
    .rst_n    (rst_n),
    .match_i  (match),
    .listed_o (listed)
  );

  always_comb begin
    pos_nxt    = pos_r;
    eth_ok_nxt = eth_ok_r;
    hw_nxt     = hw_r;
    tcp_nxt    = tcp_r;
    src_nxt    = src_r;
    ps_nxt     = ps_r;
    prefix_nxt = prefix_r;
    if (byte_fire) begin
      if (pos_r == POS_ETYPE_HI) begin
        eth_ok_nxt = (data_byte == ETHERTYPE_IPV4[15:8]);
      end else if (pos_r == POS_ETYPE_LO) begin
        eth_ok_nxt = eth_ok_r && (data_byte == ETHERTYPE_IPV4[7:0]);
      end else if (pos_r == POS_IHL) begin
        hw_nxt = data_byte[3:0];
      end else if (pos_r == POS_PROTO) begin
        tcp_nxt = (data_byte == IP_PROTO_TCP);
      end else if (pos_r >= POS_SRC_FIRST && pos_r <= POS_SRC_LAST) begin
        src_nxt = {src_r[ADDR_W-9:0], data_byte};
      end
      if (pos_r >= POS_IP_FIRST && pos_r == tcp_start + TCP_DOFF_POS) begin
        ps_nxt = tcp_start + {2'b00, data_byte[7:4], 2'b00};
      end
      if (pos_r >= POS_IP_FIRST && pos_r > tcp_start + TCP_DOFF_POS &&
          pos_r >= ps_r && {1'b0, pos_r} < ps9 + SIG_LEN) begin
        if (data_byte != sig_char(sig_off[3:0])) begin
          prefix_nxt = 1'b0;
        end
      end
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 8'd1;
      end
      if (in_tlast) begin
        pos_nxt    = '0;
        eth_ok_nxt = 1'b0;
        hw_nxt     = '0;
        tcp_nxt    = 1'b0;
        src_nxt    = '0;
        ps_nxt     = '0;
        prefix_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    drop_nxt      = drop_r;
    cause_nxt     = cause_r;
    if (frame_end) begin
      out_valid_nxt = 1'b1;
      drop_nxt      = 1'b0;
      if (len9 < MIN_FRAME || !eth_ok_r) begin
        cause_nxt = CAUSE_NOT_IP;
      end else if (listed) begin
        cause_nxt = CAUSE_LISTED;
      end else if (!tcp_r || hw_r < HDR_MIN) begin
        cause_nxt = CAUSE_NOT_TCP;
      end else if (len9 < tcp_end9 || ps9 < tcp_end9) begin
        cause_nxt = CAUSE_NOT_TCP;
      end else if (len9 < ps9 + PAYLOAD_MIN) begin
        cause_nxt = CAUSE_CLEAN;
      end else if (prefix_r) begin
        drop_nxt  = 1'b1;
        cause_nxt = CAUSE_SIGNATURE;
      end else begin
        cause_nxt = CAUSE_CLEAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      eth_ok_r    <= 1'b0;
      hw_r        <= '0;
      tcp_r       <= 1'b0;
      src_r       <= '0;
      ps_r        <= '0;
      prefix_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      eth_ok_r    <= eth_ok_nxt;
      hw_r        <= hw_nxt;
      tcp_r       <= tcp_nxt;
      src_r       <= src_nxt;
      ps_r        <= ps_nxt;
      prefix_r    <= prefix_nxt;
      out_valid_r <= out_valid_nxt;
    end
    drop_r  <= drop_nxt;
    cause_r <= cause_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, cause_r, drop_r};

  a_verdict_follows: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> out_tvalid)
    else $error("last byte taken without a verdict");

  a_drop_is_signature: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (drop_r == (cause_r == CAUSE_SIGNATURE)))
    else $error("drop flag disagrees with cause");

  a_cause_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cause_r <= CAUSE_SIGNATURE))
    else $error("cause out of range");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> (pos_r == '0) && prefix_r && !eth_ok_r)
    else $error("frame state not cleared after last byte");

  a_write_keeps_frame: assert property (@(posedge clk) disable iff (!rst_n)
    wr_fire |=> (pos_r == $past(pos_r)) && (prefix_r == $past(prefix_r)))
    else $error("allowlist write disturbed the frame");

endmodule

@@ rtl/core/itsf_cell.sv @@
// One allowlist cell: holds a slot's address and valid bit, compares it with
// the broadcast source address on lookup. Depends on itsf_pkg.
module itsf_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itsf_pkg::allow_ctl_t ctl_i,
  input  logic                 sel_i,
  output logic                 match_o
);
  import itsf_pkg::*;

  logic              valid_r, valid_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              match_r, match_nxt;

  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    match_nxt = match_r;
    if (ctl_i.write && sel_i) begin
      valid_nxt = ctl_i.valid;
      addr_nxt  = ctl_i.address;
    end
    if (ctl_i.lookup) begin
      match_nxt = valid_r && (addr_r == ctl_i.key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
    addr_r <= addr_nxt;
  end

  assign match_o = match_r;

endmodule

@@ rtl/core/itsf_match_tree.sv @@
// Registered OR tree over the cell match bits; three register levels.
// Depends on itsf_pkg.
module itsf_match_tree (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [itsf_pkg::ALLOW_ENTRIES-1:0] match_i,
  output logic                               listed_o
);
  import itsf_pkg::*;

  logic [TREE_L1-1:0] l1_r, l1_nxt;
  logic [TREE_L2-1:0] l2_r, l2_nxt;
  logic               listed_r, listed_nxt;

  always_comb begin
    for (int g = 0; g < TREE_L1; g++) begin
      l1_nxt[g] = 1'b0;
      for (int k = 0; k < TREE_FAN; k++) begin
        if (g * TREE_FAN + k < ALLOW_ENTRIES) begin
          l1_nxt[g] = l1_nxt[g] | match_i[g * TREE_FAN + k];
        end
      end
    end
    for (int g = 0; g < TREE_L2; g++) begin
      l2_nxt[g] = 1'b0;
      for (int k = 0; k < TREE_FAN; k++) begin
        if (g * TREE_FAN + k < TREE_L1) begin
          l2_nxt[g] = l2_nxt[g] | l1_r[g * TREE_FAN + k];
        end
      end
    end
    listed_nxt = |l2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r     <= '0;
      l2_r     <= '0;
      listed_r <= 1'b0;
    end else begin
      l1_r     <= l1_nxt;
      l2_r     <= l2_nxt;
      listed_r <= listed_nxt;
    end
  end

  assign listed_o = listed_r;

endmodule
